// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the shelf tile packer.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int MaxShelves   = 64;
  localparam int ShelfAw      = $clog2(MaxShelves);
  localparam int ShelfCw      = $clog2(MaxShelves + 1);
  localparam int TilesPerCube = 6;
  localparam int FaceW        = 3;
  localparam int SizeW        = 15;
  localparam int CoordW       = 14;
  localparam int EntryW       = 10;
  localparam int RankW        = 8;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 15;

  localparam logic [SizeW-1:0] AtlasLimit = SizeW'(16384);

  typedef logic [SizeW-1:0] dim_t;

  typedef struct packed {
    dim_t top;
    dim_t height;
    dim_t fill;
  } shelf_t;

  typedef struct packed {
    logic               we;
    logic [ShelfAw-1:0] waddr;
    shelf_t             wdata;
    logic [ShelfAw-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic               vld;
    logic [ShelfAw-1:0] addr;
    shelf_t             word;
  } undo_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_CMP,
    ST_NEW,
    ST_UNDO,
    ST_EMIT,
    ST_REJECT
  } stp_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATLAS_RES   = 2'd0,
    CFG_MAX_ENTRIES = 2'd1,
    CFG_MAX_LIGHTS  = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/stp_if.sv =====
// ----------------------------------------------------------------------------
// stp_if
// Request and result channels of the shelf tile packer.
// ----------------------------------------------------------------------------
interface stp_req_if
  import stp_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       new_frame;
  dim_t       tile_size;
  logic       is_cube;

  modport source (output valid, new_frame, tile_size, is_cube, input ready);
  modport sink   (input valid, new_frame, tile_size, is_cube, output ready);
endinterface

interface stp_rsp_if
  import stp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              placed;
  logic [CoordW-1:0] tile_x;
  logic [CoordW-1:0] tile_y;
  dim_t              placed_size;
  logic [FaceW-1:0]  face_index;
  logic [EntryW-1:0] base_entry;
  logic [RankW-1:0]  accepted_rank;
  logic              last;

  modport source (output valid, placed, tile_x, tile_y, placed_size, face_index,
                  base_entry, accepted_rank, last, input ready);
  modport sink   (input valid, placed, tile_x, tile_y, placed_size, face_index,
                  base_entry, accepted_rank, last, output ready);
endinterface

// ===== rtl/stp_shelf_ram.sv =====
// ----------------------------------------------------------------------------
// stp_shelf_ram
// Shelf table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stp_shelf_ram
  import stp_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output shelf_t   rdata_o
);

  shelf_t mem_q [MaxShelves];
  shelf_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/shelf_tile_packer.sv =====
// ----------------------------------------------------------------------------
// shelf_tile_packer
// First-fit shelf packing of square tiles (one, or six for a cube) into a
// square atlas, with all-or-nothing cube placement and per-frame budgets.
// ----------------------------------------------------------------------------
// Sequence: accept in ST_IDLE, check in ST_CHECK, then per tile ST_SCAN and
//   ST_CMP per open shelf walked (the shelf table read is registered), or
//   ST_SCAN and ST_NEW to open one; a failed cube undoes each placed tile in
//   ST_UNDO, restoring cursors. Results flow one per cycle while rsp_o.ready.
// Throughput: one request at a time; the next is taken after its last result.
// Reset: asynchronous; cursors and budgets clear, registers take 4096/64/32.
// ----------------------------------------------------------------------------
module shelf_tile_packer
  import stp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  stp_req_if.sink             req_i,
  stp_rsp_if.source           rsp_o
);

  stp_state_e state_q, state_d;

  dim_t              atlas_res_q;
  logic [EntryW-1:0] max_entries_q;
  logic [RankW-1:0]  max_lights_q;

  dim_t              size_q;
  logic [FaceW-1:0]  count_q;
  logic [ShelfCw-1:0] shelf_count_q, shelf_count_d;
  dim_t              next_top_q, next_top_d;
  logic [EntryW-1:0] entries_q, entries_d;
  logic [RankW-1:0]  lights_q, lights_d;
  logic [ShelfCw-1:0] saved_count_q;
  dim_t              saved_top_q;
  logic [ShelfCw-1:0] scan_q, scan_d;
  logic [FaceW-1:0]  tile_q, tile_d;
  logic [FaceW-1:0]  undo_q, undo_d;
  logic [FaceW-1:0]  face_q, face_d;

  logic [CoordW-1:0] xs_q [TilesPerCube];
  logic [CoordW-1:0] ys_q [TilesPerCube];
  undo_t             log_q [TilesPerCube];

  ram_req_t ram_req;
  shelf_t   rd_word;

  stp_shelf_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd_word)
  );

  dim_t              side;
  dim_t              add_a;
  logic [SizeW:0]    sum;
  logic              fits;
  logic [EntryW:0]   budget_sum;
  logic              reject_chk;
  logic              last_tile;
  logic              shelf_fit;
  logic              new_ok;
  logic              place_ok;
  logic              log_fit;
  logic              log_new;
  logic              in_xfer;
  logic              out_xfer;
  undo_t             undo_ent;

  assign side       = (atlas_res_q > AtlasLimit) ? AtlasLimit : atlas_res_q;
  assign add_a      = (state_q == ST_NEW) ? next_top_q : rd_word.fill;
  assign sum        = {1'b0, add_a} + {1'b0, size_q};
  assign fits       = sum <= {1'b0, side};
  assign budget_sum = {1'b0, entries_q} + (EntryW + 1)'(count_q);
  assign reject_chk = (lights_q >= max_lights_q) || (budget_sum > {1'b0, max_entries_q}) ||
                      (size_q == '0) || (size_q > side);
  assign last_tile  = tile_q == (count_q - FaceW'(1));
  assign shelf_fit  = (rd_word.height >= size_q) && fits;
  assign new_ok     = (shelf_count_q < ShelfCw'(MaxShelves)) && fits;
  assign undo_ent   = log_q[undo_q - FaceW'(1)];
  assign in_xfer    = req_i.valid && req_i.ready;
  assign out_xfer   = rsp_o.valid && rsp_o.ready;

  always_comb begin
    state_d       = state_q;
    shelf_count_d = shelf_count_q;
    next_top_d    = next_top_q;
    entries_d     = entries_q;
    lights_d      = lights_q;
    scan_d        = scan_q;
    tile_d        = tile_q;
    undo_d        = undo_q;
    face_d        = face_q;
    place_ok      = 1'b0;
    log_fit       = 1'b0;
    log_new       = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = scan_q[ShelfAw-1:0];
    ram_req.wdata = '{top: rd_word.top, height: rd_word.height, fill: sum[SizeW-1:0]};
    ram_req.raddr = scan_q[ShelfAw-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (req_i.new_frame) begin
            shelf_count_d = '0;
            next_top_d    = '0;
            entries_d     = '0;
            lights_d      = '0;
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        tile_d = '0;
        scan_d = '0;
        state_d = reject_chk ? ST_REJECT : ST_SCAN;
      end
      ST_SCAN: begin
        state_d = (scan_q < shelf_count_q) ? ST_CMP : ST_NEW;
      end
      ST_CMP: begin
        if (shelf_fit) begin
          ram_req.we = 1'b1;
          log_fit    = 1'b1;
          place_ok   = 1'b1;
        end else begin
          scan_d  = scan_q + ShelfCw'(1);
          state_d = ST_SCAN;
        end
      end
      ST_NEW: begin
        if (new_ok) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = shelf_count_q[ShelfAw-1:0];
          ram_req.wdata = '{top: next_top_q, height: size_q, fill: size_q};
          next_top_d    = sum[SizeW-1:0];
          shelf_count_d = shelf_count_q + ShelfCw'(1);
          log_new       = 1'b1;
          place_ok      = 1'b1;
        end else begin
          undo_d  = tile_q;
          state_d = ST_UNDO;
        end
      end
      ST_UNDO: begin
        if (undo_q != '0) begin
          ram_req.we    = undo_ent.vld;
          ram_req.waddr = undo_ent.addr;
          ram_req.wdata = undo_ent.word;
          undo_d        = undo_q - FaceW'(1);
        end else begin
          shelf_count_d = saved_count_q;
          next_top_d    = saved_top_q;
          state_d       = ST_REJECT;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (face_q == (count_q - FaceW'(1))) begin
            entries_d = entries_q + EntryW'(count_q);
            lights_d  = lights_q + RankW'(1);
            state_d   = ST_IDLE;
          end else begin
            face_d = face_q + FaceW'(1);
          end
        end
      end
      ST_REJECT: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (place_ok) begin
      if (last_tile) begin
        face_d  = '0;
        state_d = ST_EMIT;
      end else begin
        tile_d  = tile_q + FaceW'(1);
        scan_d  = '0;
        state_d = ST_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      atlas_res_q   <= SizeW'(4096);
      max_entries_q <= EntryW'(64);
      max_lights_q  <= RankW'(32);
      shelf_count_q <= '0;
      next_top_q    <= '0;
      entries_q     <= '0;
      lights_q      <= '0;
      scan_q        <= '0;
      tile_q        <= '0;
      undo_q        <= '0;
      face_q        <= '0;
    end else begin
      state_q       <= state_d;
      shelf_count_q <= shelf_count_d;
      next_top_q    <= next_top_d;
      entries_q     <= entries_d;
      lights_q      <= lights_d;
      scan_q        <= scan_d;
      tile_q        <= tile_d;
      undo_q        <= undo_d;
      face_q        <= face_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ATLAS_RES:   atlas_res_q   <= cfg_data_i[SizeW-1:0];
          CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[EntryW-1:0];
          CFG_MAX_LIGHTS:  max_lights_q  <= cfg_data_i[RankW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      size_q  <= req_i.tile_size;
      count_q <= req_i.is_cube ? FaceW'(TilesPerCube) : FaceW'(1);
    end
    if (state_q == ST_CHECK) begin
      saved_count_q <= shelf_count_q;
      saved_top_q   <= next_top_q;
    end
    if (log_fit) begin
      xs_q[tile_q]  <= rd_word.fill[CoordW-1:0];
      ys_q[tile_q]  <= rd_word.top[CoordW-1:0];
      log_q[tile_q] <= '{vld: 1'b1, addr: scan_q[ShelfAw-1:0], word: rd_word};
    end
    if (log_new) begin
      xs_q[tile_q]      <= '0;
      ys_q[tile_q]      <= next_top_q[CoordW-1:0];
      log_q[tile_q].vld <= 1'b0;
    end
  end

  // result channel
  logic emit;
  assign emit = state_q == ST_EMIT;

  assign req_i.ready         = state_q == ST_IDLE;
  assign rsp_o.valid         = emit || (state_q == ST_REJECT);
  assign rsp_o.placed        = emit;
  assign rsp_o.tile_x        = emit ? xs_q[face_q] : '0;
  assign rsp_o.tile_y        = emit ? ys_q[face_q] : '0;
  assign rsp_o.placed_size   = emit ? size_q : '0;
  assign rsp_o.face_index    = emit ? face_q : '0;
  assign rsp_o.base_entry    = emit ? entries_q : '0;
  assign rsp_o.accepted_rank = emit ? lights_q : '0;
  assign rsp_o.last          = emit ? (face_q == (count_q - FaceW'(1))) : 1'b1;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("request taken while a result is pending");

  a_shelf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shelf_count_q <= ShelfCw'(MaxShelves))
    else $error("shelf count past table depth");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !rsp_o.placed) |=> ($stable(entries_q) && $stable(lights_q) &&
                                     $stable(shelf_count_q) && $stable(next_top_q)))
    else $error("rejected request changed packer state");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && rsp_o.last) |=> req_i.ready)
    else $error("not ready after final result transfer");
`endif

endmodule
